// ----- hdl/adam_pkg.sv -----
// Shared types and constants of the Adam update core.
// Used by adam_front, adam_back, adam_div and adam_optimizer_update_core.
`default_nettype none

package adam_pkg;

    localparam int IDX_W = 12;
    localparam int VAL_W = 32;
    localparam int CFG_IDX_W = 3;

    // One in Q1.32
    localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA_FIRST    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA_SECOND   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_FACTOR  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_EPSILON_TERM  = 3'd4;

    // Operation codes of an input word
    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_RESET  = 1'b1;

    typedef struct packed {
        logic                    is_reset;
        logic                    last;
        logic [IDX_W-1:0]        index;
        logic signed [VAL_W-1:0] grad;
        logic signed [VAL_W-1:0] param;
    } t_cmd;

    typedef struct packed {
        logic [31:0] lr;
        logic [31:0] b1;
        logic [31:0] b2;
        logic [31:0] decay;
        logic [31:0] eps;
    } t_cfg;

    typedef struct packed {
        logic        start;
        logic [32:0] rem;
        logic [31:0] low;
        logic [32:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic        ovf;
        logic [31:0] quot;
    } t_div_rsp;

endpackage

`default_nettype wire

// ----- hdl/adam_div.sv -----
// Shared restoring divider, one quotient bit per cycle, 32-bit quotient.
// Depends on adam_pkg (request and response structs).
`default_nettype none

module adam_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire adam_pkg::t_div_req i_req,
    output adam_pkg::t_div_rsp     o_rsp
);

    logic        r_busy;
    logic        r_done;
    logic        r_ovf;
    logic [4:0]  r_cnt;
    logic [32:0] r_rem;
    logic [31:0] r_low;
    logic [32:0] r_div;
    logic [31:0] r_quot;

    logic [33:0] w_trial;
    logic        w_ge;
    logic [33:0] w_diff;

    assign w_trial = {r_rem, r_low[31]};
    assign w_ge    = w_trial >= {1'b0, r_div};
    assign w_diff  = w_trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_ovf  <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_rem  <= i_req.rem;
                r_low  <= i_req.low;
                r_div  <= i_req.divisor;
                r_cnt  <= '0;
                // flag a quotient that would not fit 32 bits; done still comes
                // after the full 32 steps
                r_ovf  <= (i_req.rem >= i_req.divisor);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem  <= w_ge ? w_diff[32:0] : w_trial[32:0];
                r_quot <= {r_quot[30:0], w_ge};
                r_low  <= {r_low[30:0], 1'b0};
                r_cnt  <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp = '{busy: r_busy, done: r_done, ovf: r_ovf, quot: r_quot};

endmodule

`default_nettype wire

// ----- hdl/adam_front.sv -----
// Input side: accepts words, classifies them and queues them two deep.
// Depends on adam_pkg (t_cmd).
`default_nettype none

module adam_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic                        i_operation,
    input  wire logic [adam_pkg::IDX_W-1:0]  i_element_index,
    input  wire logic signed [adam_pkg::VAL_W-1:0] i_gradient,
    input  wire logic signed [adam_pkg::VAL_W-1:0] i_param_value,
    input  wire logic                        i_last_in_step,
    input  wire logic                        i_hold,
    output adam_pkg::t_cmd                   o_cmd,
    output logic                             o_cmd_valid,
    input  wire logic                        i_cmd_pop
);

    adam_pkg::t_cmd r_q [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;

    logic w_push;
    logic w_pop;

    assign o_in_stall  = (r_cnt == 2'd2) || i_hold;
    assign w_push      = i_in_valid && !o_in_stall;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign w_pop       = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= '{is_reset: (i_operation == adam_pkg::OP_RESET),
                           last:     i_last_in_step,
                           index:    i_element_index,
                           grad:     i_gradient,
                           param:    i_param_value};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= !r_wp;
            if (w_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

endmodule

`default_nettype wire

// ----- hdl/adam_back.sv -----
// Execution side: moment memories, shared multiplier, square root, sequencer
// and output register. Depends on adam_pkg; drives the shared adam_div.
`default_nettype none

module adam_back #(
    parameter int MOMENT_DEPTH = 4096
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire adam_pkg::t_cfg             i_cfg,
    input  wire adam_pkg::t_cmd             i_cmd,
    input  wire logic                       i_cmd_valid,
    output logic                            o_cmd_pop,
    output logic                            o_hold,
    output adam_pkg::t_div_req              o_div_req,
    input  wire adam_pkg::t_div_rsp         i_div_rsp,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output logic [adam_pkg::IDX_W-1:0]      o_out_index,
    output logic signed [adam_pkg::VAL_W-1:0] o_new_value,
    output logic                            o_saturated
);

    localparam int AW = $clog2(MOMENT_DEPTH);
    localparam logic signed [39:0] S_MAX = 40'sd2147483647;
    localparam logic signed [39:0] S_MIN = -40'sd2147483648;
    localparam logic signed [39:0] U_MAX = 40'sd4294967295;
    localparam logic signed [31:0] V_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] V_MIN = 32'sh8000_0000;

    typedef enum logic [5:0] {
        S_CLEAR, S_IDLE, S_SLOT, S_READ, S_W1, S_GD, S_W2, S_M1, S_W3, S_M2,
        S_W4, S_SQ, S_W5, S_V1, S_W6, S_V2, S_W7, S_C1, S_W8, S_C2, S_DIV1,
        S_MH, S_DIV2, S_VH, S_ROOT, S_RQ, S_DIV3, S_RR, S_RL, S_W9, S_NV, S_OUT
    } t_state;

    function automatic logic f_sat_s(input logic signed [39:0] x);
        return (x > S_MAX) || (x < S_MIN);
    endfunction

    function automatic logic signed [31:0] f_clamp_s(input logic signed [39:0] x);
        if (x > S_MAX) return V_MAX;
        if (x < S_MIN) return V_MIN;
        return x[31:0];
    endfunction

    function automatic logic signed [33:0] f_sx34(input logic signed [31:0] x);
        return {{2{x[31]}}, x};
    endfunction

    function automatic logic signed [39:0] f_sx40(input logic signed [31:0] x);
        return {{8{x[31]}}, x};
    endfunction

    // magnitude to signed with clamp; f_sign_mag_sat reports when it clamps
    function automatic logic signed [31:0] f_sign_mag(input logic neg, input logic ovf,
                                                      input logic [31:0] mag);
        if (neg) begin
            if (ovf || mag > 32'h8000_0000) return V_MIN;
            return 32'(-mag);
        end
        if (ovf || mag > 32'h7FFF_FFFF) return V_MAX;
        return mag;
    endfunction

    function automatic logic f_sign_mag_sat(input logic neg, input logic ovf,
                                            input logic [31:0] mag);
        return ovf || (neg ? (mag > 32'h8000_0000) : (mag > 32'h7FFF_FFFF));
    endfunction

    t_state                r_state;
    adam_pkg::t_cmd        r_cmd;
    logic [AW-1:0]         r_clr;
    logic [11:0]           r_slot;
    logic [3:0]            r_k;
    logic                  r_sat;
    logic signed [33:0]    r_ma;
    logic signed [33:0]    r_mb;
    logic signed [67:0]    r_prod;
    logic signed [39:0]    r_acc;
    logic signed [31:0]    r_gd;
    logic signed [31:0]    r_m;
    logic [31:0]           r_sq;
    logic [31:0]           r_v;
    logic [31:0]           r_pb1;
    logic [31:0]           r_pb2;
    logic [32:0]           r_c2;
    logic [32:0]           r_pw1;
    logic [32:0]           r_pw2;
    logic [31:0]           r_amh;
    logic                  r_mneg;
    logic [55:0]           r_sq_op;
    logic [55:0]           r_sq_res;
    logic [55:0]           r_sq_bit;
    logic signed [31:0]    r_r;
    logic signed [31:0]    r_nv;
    logic                  r_out_valid;
    logic [11:0]           r_out_index;
    logic signed [31:0]    r_out_value;
    logic                  r_out_sat;

    logic signed [31:0]    r_m_mem [MOMENT_DEPTH];
    logic [31:0]           r_v_mem [MOMENT_DEPTH];
    logic                  r_vld_mem [MOMENT_DEPTH];
    logic signed [31:0]    r_m_rd;
    logic [31:0]           r_v_rd;
    logic                  r_vld_rd;

    logic [AW-1:0]         w_addr;
    logic signed [39:0]    w_sh;
    logic signed [39:0]    w_gd_sum;
    logic signed [39:0]    w_m_sum;
    logic signed [39:0]    w_v_sum;
    logic signed [39:0]    w_nv_sum;
    logic [31:0]           w_v;
    logic [31:0]           w_m_mag;
    logic [31:0]           w_gd_mag;
    logic                  w_slot_ge;
    logic signed [31:0]    w_mh;
    logic [31:0]           w_vh;
    logic [32:0]           w_x;
    logic [55:0]           w_sq_t;
    logic [27:0]           w_root;
    logic [32:0]           w_omb1;
    logic [32:0]           w_omb2;

    assign w_addr    = AW'(r_slot);
    assign w_sh      = {{4{r_prod[67]}}, r_prod[67:32]};
    assign w_gd_sum  = f_sx40(r_cmd.grad) + w_sh;
    assign w_m_sum   = r_acc + w_sh;
    assign w_v_sum   = r_acc + w_sh;
    assign w_nv_sum  = f_sx40(r_cmd.param) - w_sh;
    assign w_v       = (w_v_sum > U_MAX) ? 32'hFFFF_FFFF : w_v_sum[31:0];
    assign w_m_mag   = r_m[31] ? 32'(-r_m) : r_m;
    assign w_gd_mag  = r_gd[31] ? 32'(-r_gd) : r_gd;
    assign w_slot_ge = {20'd0, r_slot} >= (32'(MOMENT_DEPTH) << r_k);
    assign w_mh      = f_sign_mag(r_m[31], i_div_rsp.ovf, i_div_rsp.quot);
    assign w_vh      = i_div_rsp.ovf ? 32'hFFFF_FFFF : i_div_rsp.quot;
    assign w_x       = {1'b0, w_vh} + {1'b0, i_cfg.eps};
    assign w_sq_t    = r_sq_res + r_sq_bit;
    assign w_root    = r_sq_res[27:0];
    assign w_omb1    = adam_pkg::ONE_Q32 - {1'b0, i_cfg.b1};
    assign w_omb2    = adam_pkg::ONE_Q32 - {1'b0, i_cfg.b2};

    assign o_cmd_pop = (r_state == S_IDLE) && i_cmd_valid;
    assign o_hold    = (r_state == S_CLEAR);

    // divider launches: m_hat, v_hat, then the step ratio unless the root is zero
    always_comb begin
        o_div_req = '0;
        case (r_state)
            S_C1: begin
                o_div_req.start   = 1'b1;
                o_div_req.rem     = {1'b0, w_m_mag};
                o_div_req.divisor = adam_pkg::ONE_Q32 - {1'b0, r_prod[63:32]};
            end
            S_MH: begin
                o_div_req.start   = 1'b1;
                o_div_req.rem     = {1'b0, r_v};
                o_div_req.divisor = r_c2;
            end
            S_RQ: begin
                o_div_req.start   = (w_root != 28'd0);
                o_div_req.rem     = {9'd0, r_amh[31:8]};
                o_div_req.low     = {r_amh[7:0], 24'd0};
                o_div_req.divisor = {5'd0, w_root};
            end
            default: begin
                o_div_req = '0;
            end
        endcase
    end

    // moment and valid memories
    always_ff @(posedge i_clk) begin
        if (r_state == S_V2) begin
            r_m_mem[w_addr] <= r_m;
            r_v_mem[w_addr] <= w_v;
        end
        if (r_state == S_CLEAR) begin
            r_vld_mem[r_clr] <= 1'b0;
        end else if (r_state == S_V2) begin
            r_vld_mem[w_addr] <= 1'b1;
        end
        r_m_rd   <= r_m_mem[w_addr];
        r_v_rd   <= r_v_mem[w_addr];
        r_vld_rd <= r_vld_mem[w_addr];
    end

    always_ff @(posedge i_clk) begin
        r_prod <= r_ma * r_mb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_pw1       <= adam_pkg::ONE_Q32;
            r_pw2       <= adam_pkg::ONE_Q32;
            r_out_valid <= 1'b0;
            r_sat       <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && (r_state != S_OUT)) r_out_valid <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(MOMENT_DEPTH - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd <= i_cmd;
                        r_sat <= 1'b0;
                        if (i_cmd.is_reset) begin
                            r_pw1   <= adam_pkg::ONE_Q32;
                            r_pw2   <= adam_pkg::ONE_Q32;
                            r_clr   <= '0;
                            r_state <= S_CLEAR;
                        end else begin
                            r_slot  <= i_cmd.index;
                            r_k     <= 4'd11;
                            r_state <= S_SLOT;
                        end
                    end
                end
                S_SLOT: begin
                    // reduce the index modulo the depth, one shifted subtract a cycle
                    if (w_slot_ge) r_slot <= r_slot - 12'(32'(MOMENT_DEPTH) << r_k);
                    r_k <= r_k - 4'd1;
                    if (r_k == 4'd0) r_state <= S_READ;
                end
                S_READ: begin
                    r_ma    <= f_sx34(r_cmd.param);
                    r_mb    <= {2'b00, i_cfg.decay};
                    r_state <= S_W1;
                end
                S_W1: r_state <= S_GD;
                S_GD: begin
                    r_gd    <= f_clamp_s(w_gd_sum);
                    r_sat   <= r_sat | f_sat_s(w_gd_sum);
                    r_ma    <= r_vld_rd ? f_sx34(r_m_rd) : 34'sd0;
                    r_mb    <= {2'b00, i_cfg.b1};
                    r_state <= S_W2;
                end
                S_W2: r_state <= S_M1;
                S_M1: begin
                    r_acc   <= w_sh;
                    r_ma    <= f_sx34(r_gd);
                    r_mb    <= {1'b0, w_omb1};
                    r_state <= S_W3;
                end
                S_W3: r_state <= S_M2;
                S_M2: begin
                    r_m     <= f_clamp_s(w_m_sum);
                    r_sat   <= r_sat | f_sat_s(w_m_sum);
                    r_state <= S_W4;
                    r_ma    <= {2'b00, w_gd_mag};
                    r_mb    <= {2'b00, w_gd_mag};
                end
                S_W4: r_state <= S_SQ;
                S_SQ: begin
                    // g'^2 in Q16.48 down to Q8.24
                    r_sq    <= (r_prod[67:56] != 12'd0) ? 32'hFFFF_FFFF : r_prod[55:24];
                    r_sat   <= r_sat | (r_prod[67:56] != 12'd0);
                    r_ma    <= r_vld_rd ? {2'b00, r_v_rd} : 34'sd0;
                    r_mb    <= {2'b00, i_cfg.b2};
                    r_state <= S_W5;
                end
                S_W5: r_state <= S_V1;
                S_V1: begin
                    r_acc   <= w_sh;
                    r_ma    <= {2'b00, r_sq};
                    r_mb    <= {1'b0, w_omb2};
                    r_state <= S_W6;
                end
                S_W6: r_state <= S_V2;
                S_V2: begin
                    r_v     <= w_v;
                    r_sat   <= r_sat | (w_v_sum > U_MAX);
                    r_ma    <= {1'b0, r_pw1};
                    r_mb    <= {2'b00, i_cfg.b1};
                    r_state <= S_W7;
                end
                S_W7: r_state <= S_C1;
                S_C1: begin
                    r_pb1   <= r_prod[63:32];
                    r_ma    <= {1'b0, r_pw2};
                    r_mb    <= {2'b00, i_cfg.b2};
                    r_state <= S_W8;
                end
                S_W8: r_state <= S_C2;
                S_C2: begin
                    r_pb2   <= r_prod[63:32];
                    r_c2    <= adam_pkg::ONE_Q32 - {1'b0, r_prod[63:32]};
                    r_state <= S_DIV1;
                end
                S_DIV1: begin
                    if (i_div_rsp.done) r_state <= S_MH;
                end
                S_MH: begin
                    r_amh   <= w_mh[31] ? 32'(-w_mh) : w_mh;
                    r_mneg  <= w_mh[31];
                    r_sat   <= r_sat | f_sign_mag_sat(r_m[31], i_div_rsp.ovf, i_div_rsp.quot);
                    r_state <= S_DIV2;
                end
                S_DIV2: begin
                    if (i_div_rsp.done) r_state <= S_VH;
                end
                S_VH: begin
                    r_sat    <= r_sat | i_div_rsp.ovf | w_x[32];
                    r_sq_op  <= {(w_x[32] ? 32'hFFFF_FFFF : w_x[31:0]), 24'd0};
                    r_sq_res <= '0;
                    r_sq_bit <= 56'd1 << 54;
                    r_state  <= S_ROOT;
                end
                S_ROOT: begin
                    if (r_sq_op >= w_sq_t) begin
                        r_sq_op  <= r_sq_op - w_sq_t;
                        r_sq_res <= (r_sq_res >> 1) + r_sq_bit;
                    end else begin
                        r_sq_res <= r_sq_res >> 1;
                    end
                    r_sq_bit <= r_sq_bit >> 2;
                    if (r_sq_bit[0]) r_state <= S_RQ;
                end
                S_RQ: begin
                    if (w_root == 28'd0) begin
                        // zero root: ratio is zero or the limit of m_hat's sign
                        r_r     <= (r_amh == 32'd0) ? 32'sd0 : (r_mneg ? V_MIN : V_MAX);
                        r_sat   <= r_sat | (r_amh != 32'd0);
                        r_state <= S_RL;
                    end else begin
                        r_state <= S_DIV3;
                    end
                end
                S_DIV3: begin
                    if (i_div_rsp.done) r_state <= S_RR;
                end
                S_RR: begin
                    r_r     <= f_sign_mag(r_mneg, i_div_rsp.ovf, i_div_rsp.quot);
                    r_sat   <= r_sat | f_sign_mag_sat(r_mneg, i_div_rsp.ovf, i_div_rsp.quot);
                    r_state <= S_RL;
                end
                S_RL: begin
                    r_ma    <= f_sx34(r_r);
                    r_mb    <= {2'b00, i_cfg.lr};
                    r_state <= S_W9;
                end
                S_W9: r_state <= S_NV;
                S_NV: begin
                    r_nv  <= f_clamp_s(w_nv_sum);
                    r_sat <= r_sat | f_sat_s(w_nv_sum);
                    if (r_cmd.last) begin
                        r_pw1 <= {1'b0, r_pb1};
                        r_pw2 <= {1'b0, r_pb2};
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_out_index <= r_cmd.index;
                        r_out_value <= r_nv;
                        r_out_sat   <= r_sat;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_index = r_out_index;
    assign o_new_value = r_out_value;
    assign o_saturated = r_out_sat;

    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_state == S_CLEAR))
        else $error("clearing pass does not follow reset");

    a_power_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pw1 <= adam_pkg::ONE_Q32) && (r_pw2 <= adam_pkg::ONE_Q32))
        else $error("beta power above one");

    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_div_req.start |-> !i_div_rsp.busy)
        else $error("divider started while busy");

    a_root_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RQ) |-> (r_sq_res[55:28] == 28'd0))
        else $error("square root wider than 28 bits");

endmodule

`default_nettype wire

// ----- hdl/adam_optimizer_update_core.sv -----
// Adam optimizer element update in Q8.24. One update word yields one result word
// (index, new value, saturated); a reset word clears the moment history and
// yields none. An update word runs the shared 32-step divider for m_hat, v_hat
// and, unless the root is zero, the step ratio, and passes the 28-step square
// root and a 12-step index reduction; words are processed one at a time while a
// two-deep queue keeps taking input until it is full. After reset, and for each
// reset word, a clearing pass sweeps all MOMENT_DEPTH valid bits; no input word
// is taken during it. Configuration writes are always ready and are expected
// only while the core is idle.
`default_nettype none

module adam_optimizer_update_core #(
    parameter int MOMENT_DEPTH = 4096
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // configuration write channel
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [adam_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [31:0]                       i_cfg_data,
    // input words
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic                              i_operation,
    input  wire logic [adam_pkg::IDX_W-1:0]        i_element_index,
    input  wire logic signed [adam_pkg::VAL_W-1:0] i_gradient,
    input  wire logic signed [adam_pkg::VAL_W-1:0] i_param_value,
    input  wire logic                              i_last_in_step,
    // result words
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic [adam_pkg::IDX_W-1:0]             o_out_index,
    output logic signed [adam_pkg::VAL_W-1:0]      o_new_value,
    output logic                                   o_saturated
);

    adam_pkg::t_cfg     r_cfg;
    adam_pkg::t_cmd     w_cmd;
    logic               w_cmd_valid;
    logic               w_cmd_pop;
    logic               w_hold;
    adam_pkg::t_div_req w_div_req;
    adam_pkg::t_div_rsp w_div_rsp;

    assign o_cfg_ready = 1'b1;

    // configuration registers; indexes beyond the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lr    <= 32'd4294967;
            r_cfg.b1    <= 32'd3865470566;
            r_cfg.b2    <= 32'd4290672329;
            r_cfg.decay <= 32'd0;
            r_cfg.eps   <= 32'd1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                adam_pkg::CFG_LEARNING_RATE: r_cfg.lr    <= i_cfg_data;
                adam_pkg::CFG_BETA_FIRST:    r_cfg.b1    <= i_cfg_data;
                adam_pkg::CFG_BETA_SECOND:   r_cfg.b2    <= i_cfg_data;
                adam_pkg::CFG_DECAY_FACTOR:  r_cfg.decay <= i_cfg_data;
                adam_pkg::CFG_EPSILON_TERM:  r_cfg.eps   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // front: accept, classify, queue
    adam_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_operation     (i_operation),
        .i_element_index (i_element_index),
        .i_gradient      (i_gradient),
        .i_param_value   (i_param_value),
        .i_last_in_step  (i_last_in_step),
        .i_hold          (w_hold),
        .o_cmd           (w_cmd),
        .o_cmd_valid     (w_cmd_valid),
        .i_cmd_pop       (w_cmd_pop)
    );

    // shared divider for both bias corrections and the step ratio
    adam_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // back: moment update, corrections, root, output register
    adam_back #(
        .MOMENT_DEPTH (MOMENT_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (w_cmd),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_pop   (w_cmd_pop),
        .o_hold      (w_hold),
        .o_div_req   (w_div_req),
        .i_div_rsp   (w_div_rsp),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_index (o_out_index),
        .o_new_value (o_new_value),
        .o_saturated (o_saturated)
    );

endmodule

`default_nettype wire
